// ----- design/command_frame_receiver_top_assert.svh -----
// ----------------------------------------------------------------------------
// command_frame_receiver_top_assert.svh
// assertion macros for the command frame receiver
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// checked outside reset
`define CFR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("cfr assertion failed");

// checked at every edge, reset included
`define CFR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("cfr assertion failed");

`else

`define CFR_ASSERT(label, prop)
`define CFR_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- design/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// constants and types of the command frame receiver
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 18;

    localparam logic [7:0] HDR_FIRST  = 8'h24;
    localparam logic [7:0] HDR_SECOND = 8'h3C;

    localparam int DOSE_W = 14;

    localparam logic [7:0] TYPE_CLEAR       = 8'd0;
    localparam logic [7:0] TYPE_DOSE        = 8'd1;
    localparam logic [7:0] TYPE_VENTILATION = 8'd2;
    localparam logic [7:0] TYPE_BLUE_LED    = 8'd3;
    localparam logic [7:0] TYPE_SENSORS     = 8'd4;
    localparam logic [7:0] TYPE_RED_TEMP    = 8'd5;
    localparam logic [7:0] TYPE_RED_INFO    = 8'd6;
    localparam logic [7:0] TYPE_SERVICE     = 8'd7;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_DOLLAR  = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

    // argument times 48 as two shifted adds
    function automatic logic [DOSE_W-1:0] dose_scale(input logic [7:0] arg);
        logic [DOSE_W-1:0] wide;
        wide = {{(DOSE_W-8){1'b0}}, arg};
        return (wide << 5) + (wide << 4);
    endfunction

endpackage

// ----- design/command_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// command_frame_receiver_top
// byte stream command frame receiver with held settings
// ----------------------------------------------------------------------------
// Input channel s_*: one received serial byte per request (s_rx_byte).
// The block hunts for the header '$' '<', then collects PAYLOAD_BYTES bytes;
// the last one must equal the XOR of the others. After the last payload byte
// of every frame one request leaves on m_*: checksum flag, frame type, a
// clear-counters pulse and the held settings as they stand after the frame.
// Bytes outside a frame give no result.
// A byte is registered at the input, then decoded; the decode of a frame's
// last byte loads the result register and raises m_valid.
// Throughput: one byte per cycle unless a closing byte waits on a held result,
// set by the single decode step between the input and result registers.
// Reset (aresetn low, synchronous): header hunt restarts, both registers
// empty, all held settings zero.
// Stall: while m_ready is low a waiting result holds; bytes that give no
// result keep flowing, and a byte that closes a frame waits in the input
// register, after which s_ready drops.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_top_assert.svh"

module command_frame_receiver_top #(
    parameter int PAYLOAD_BYTES = cfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_checksum_ok,
    output logic [7:0]                m_frame_type,
    output logic                      m_clear_counters,
    output logic [cfr_pkg::DOSE_W-1:0] m_dose_value,
    output logic [7:0]                m_ventilation_on,
    output logic [7:0]                m_blue_led_on,
    output logic [7:0]                m_right_sensor_enable,
    output logic [7:0]                m_left_sensor_enable,
    output logic [7:0]                m_red_temp_led,
    output logic [7:0]                m_red_info_led,
    output logic [7:0]                m_service_mode
);

    localparam int IDX_W = $clog2(PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg, in_byte_next;

    cfr_pkg::phase_t      phase_reg, phase_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [7:0]           xor_reg, xor_next;
    logic [7:0]           type_reg, type_next;
    logic [7:0]           arg1_reg, arg1_next;
    logic [7:0]           arg2_reg, arg2_next;

    logic [cfr_pkg::DOSE_W-1:0] dose_reg, dose_next;
    logic [7:0]           vent_reg, vent_next;
    logic [7:0]           blue_reg, blue_next;
    logic [7:0]           right_reg, right_next;
    logic [7:0]           left_reg, left_next;
    logic [7:0]           rtemp_reg, rtemp_next;
    logic [7:0]           rinfo_reg, rinfo_next;
    logic [7:0]           service_reg, service_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 ok_reg, ok_next;
    logic [7:0]           otype_reg, otype_next;
    logic                 clr_reg, clr_next;

    logic                 closes_frame;
    logic                 advance;
    logic                 ok;

    assign closes_frame = (phase_reg == cfr_pkg::PH_COLLECT) && (idx_reg == LAST_IDX);
    assign advance = in_valid_reg && (!closes_frame || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign ok = (in_byte_reg == xor_reg);

    always_comb begin
        in_valid_next = in_valid_reg && !advance;
        in_byte_next  = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        xor_next       = xor_reg;
        type_next      = type_reg;
        arg1_next      = arg1_reg;
        arg2_next      = arg2_reg;
        dose_next      = dose_reg;
        vent_next      = vent_reg;
        blue_next      = blue_reg;
        right_next     = right_reg;
        left_next      = left_reg;
        rtemp_next     = rtemp_reg;
        rinfo_next     = rinfo_reg;
        service_next   = service_reg;
        out_valid_next = out_valid_reg && !m_ready;
        ok_next        = ok_reg;
        otype_next     = otype_reg;
        clr_next       = clr_reg;

        if (advance) begin
            unique case (phase_reg)
                cfr_pkg::PH_HUNT: begin
                    phase_next = (in_byte_reg == cfr_pkg::HDR_FIRST) ?
                                 cfr_pkg::PH_DOLLAR : cfr_pkg::PH_HUNT;
                end
                cfr_pkg::PH_DOLLAR: begin
                    if (in_byte_reg == cfr_pkg::HDR_SECOND) begin
                        phase_next = cfr_pkg::PH_COLLECT;
                        idx_next   = '0;
                        xor_next   = '0;
                    end else if (in_byte_reg != cfr_pkg::HDR_FIRST) begin
                        phase_next = cfr_pkg::PH_HUNT;
                    end
                end
                cfr_pkg::PH_COLLECT: begin
                    if (!closes_frame) begin
                        if (idx_reg == IDX_W'(0)) type_next = in_byte_reg;
                        if (idx_reg == IDX_W'(1)) arg1_next = in_byte_reg;
                        if (idx_reg == IDX_W'(2)) arg2_next = in_byte_reg;
                        xor_next = xor_reg ^ in_byte_reg;
                        idx_next = idx_reg + IDX_W'(1);
                    end else begin
                        clr_next = 1'b0;
                        if (ok) begin
                            case (type_reg)
                                cfr_pkg::TYPE_CLEAR:       clr_next = 1'b1;
                                cfr_pkg::TYPE_DOSE:        dose_next = cfr_pkg::dose_scale(arg1_reg);
                                cfr_pkg::TYPE_VENTILATION: vent_next = arg1_reg;
                                cfr_pkg::TYPE_BLUE_LED:    blue_next = arg1_reg;
                                cfr_pkg::TYPE_SENSORS: begin
                                    right_next = arg1_reg;
                                    left_next  = arg2_reg;
                                end
                                cfr_pkg::TYPE_RED_TEMP:    rtemp_next = arg1_reg;
                                cfr_pkg::TYPE_RED_INFO:    rinfo_next = arg1_reg;
                                cfr_pkg::TYPE_SERVICE:     service_next = arg1_reg;
                                default: ;
                            endcase
                        end
                        phase_next     = cfr_pkg::PH_HUNT;
                        idx_next       = '0;
                        xor_next       = '0;
                        out_valid_next = 1'b1;
                        ok_next        = ok;
                        otype_next     = type_reg;
                    end
                end
                default: begin
                    phase_next = cfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= cfr_pkg::PH_HUNT;
            idx_reg       <= '0;
            xor_reg       <= '0;
            dose_reg      <= '0;
            vent_reg      <= '0;
            blue_reg      <= '0;
            right_reg     <= '0;
            left_reg      <= '0;
            rtemp_reg     <= '0;
            rinfo_reg     <= '0;
            service_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            xor_reg       <= xor_next;
            dose_reg      <= dose_next;
            vent_reg      <= vent_next;
            blue_reg      <= blue_next;
            right_reg     <= right_next;
            left_reg      <= left_next;
            rtemp_reg     <= rtemp_next;
            rinfo_reg     <= rinfo_next;
            service_reg   <= service_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        type_reg    <= type_next;
        arg1_reg    <= arg1_next;
        arg2_reg    <= arg2_next;
        ok_reg      <= ok_next;
        otype_reg   <= otype_next;
        clr_reg     <= clr_next;
    end

    // held settings only change when a result is loaded, so they follow it
    assign m_valid               = out_valid_reg;
    assign m_checksum_ok         = ok_reg;
    assign m_frame_type          = otype_reg;
    assign m_clear_counters      = clr_reg;
    assign m_dose_value          = dose_reg;
    assign m_ventilation_on      = vent_reg;
    assign m_blue_led_on         = blue_reg;
    assign m_right_sensor_enable = right_reg;
    assign m_left_sensor_enable  = left_reg;
    assign m_red_temp_led        = rtemp_reg;
    assign m_red_info_led        = rinfo_reg;
    assign m_service_mode        = service_reg;

    `CFR_ASSERT_ALWAYS(a_reset_clears,
        !aresetn |=> !m_valid && !in_valid_reg && phase_reg == cfr_pkg::PH_HUNT)
    `CFR_ASSERT(a_clear_needs_pass,
        m_valid && m_clear_counters |-> m_checksum_ok && m_frame_type == cfr_pkg::TYPE_CLEAR)
    `CFR_ASSERT(a_blocked_byte_holds,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
    `CFR_ASSERT(a_index_in_range, phase_reg == cfr_pkg::PH_COLLECT |-> idx_reg <= LAST_IDX)

endmodule

// ----- verif/command_frame_receiver_checker.sv -----
// ----------------------------------------------------------------------------
// command_frame_receiver_checker
// Watches the byte and result channels of the command frame receiver. It
// tracks the header hunt, the payload XOR and the held settings in its own
// model, queues one report per completed frame, and compares every accepted
// result with the oldest queued report, field by field.
// ----------------------------------------------------------------------------
module command_frame_receiver_checker
    import cfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_checksum_ok,
    input  logic [7:0]        m_frame_type,
    input  logic              m_clear_counters,
    input  logic [DOSE_W-1:0] m_dose_value,
    input  logic [7:0]        m_ventilation_on,
    input  logic [7:0]        m_blue_led_on,
    input  logic [7:0]        m_right_sensor_enable,
    input  logic [7:0]        m_left_sensor_enable,
    input  logic [7:0]        m_red_temp_led,
    input  logic [7:0]        m_red_info_led,
    input  logic [7:0]        m_service_mode,
    output int                mismatch_count,
    output int                frames_due,
    output int                reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD   = PAYLOAD_BYTES_DEF;
    localparam int DOSE_MULT = 48;

    typedef struct {
        logic              ok;
        logic [7:0]        ftype;
        logic              clr;
        logic [DOSE_W-1:0] dose;
        logic [7:0]        vent;
        logic [7:0]        blue;
        logic [7:0]        right_en;
        logic [7:0]        left_en;
        logic [7:0]        red_temp;
        logic [7:0]        red_info;
        logic [7:0]        service;
    } frame_report_t;

    frame_report_t report_q[$];
    frame_report_t settings;
    phase_t        phase;
    logic [4:0]    index;
    logic [7:0]    xor_acc;
    logic [7:0]    type_byte;
    logic [7:0]    arg1;
    logic [7:0]    arg2;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        frame_report_t rpt;
        if (phase == PH_DOLLAR) begin
            if (b == HDR_SECOND) begin
                phase   = PH_COLLECT;
                index   = '0;
                xor_acc = '0;
            end else if (b != HDR_FIRST) begin
                phase = PH_HUNT;
            end
        end else if (phase != PH_COLLECT) begin
            phase = (b == HDR_FIRST) ? PH_DOLLAR : PH_HUNT;
        end else if (index < PAYLOAD - 1) begin
            if (index == 0) type_byte = b;
            else if (index == 1) arg1 = b;
            else if (index == 2) arg2 = b;
            xor_acc = xor_acc ^ b;
            index   = index + 1'b1;
        end else begin
            rpt = settings;
            rpt.ok = (b == xor_acc);
            rpt.clr = 1'b0;
            if (rpt.ok) begin
                case (type_byte)
                    TYPE_CLEAR:       rpt.clr = 1'b1;
                    TYPE_DOSE:        rpt.dose = DOSE_W'(int'(arg1) * DOSE_MULT);
                    TYPE_VENTILATION: rpt.vent = arg1;
                    TYPE_BLUE_LED:    rpt.blue = arg1;
                    TYPE_SENSORS: begin
                        rpt.right_en = arg1;
                        rpt.left_en  = arg2;
                    end
                    TYPE_RED_TEMP:    rpt.red_temp = arg1;
                    TYPE_RED_INFO:    rpt.red_info = arg1;
                    TYPE_SERVICE:     rpt.service = arg1;
                    default: ;
                endcase
            end
            rpt.ftype = type_byte;
            settings  = rpt;
            report_q.push_back(rpt);
            phase   = PH_HUNT;
            index   = '0;
            xor_acc = '0;
        end
    endtask

    always @(posedge aclk) begin
        frame_report_t want;
        if (!aresetn) begin
            phase           = PH_HUNT;
            index           = '0;
            xor_acc         = '0;
            type_byte       = '0;
            arg1            = '0;
            arg2            = '0;
            settings        = '{default: '0};
            report_q.delete();
            mismatch_count  = 0;
            reports_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    $error("result with no frame pending: frame_type %0d", m_frame_type);
                    mismatch_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("checksum_ok", 32'(want.ok), 32'(m_checksum_ok));
                    check_field("frame_type", 32'(want.ftype), 32'(m_frame_type));
                    check_field("clear_counters", 32'(want.clr), 32'(m_clear_counters));
                    check_field("dose_value", 32'(want.dose), 32'(m_dose_value));
                    check_field("ventilation_on", 32'(want.vent), 32'(m_ventilation_on));
                    check_field("blue_led_on", 32'(want.blue), 32'(m_blue_led_on));
                    check_field("right_sensor_enable", 32'(want.right_en),
                                32'(m_right_sensor_enable));
                    check_field("left_sensor_enable", 32'(want.left_en),
                                32'(m_left_sensor_enable));
                    check_field("red_temp_led", 32'(want.red_temp), 32'(m_red_temp_led));
                    check_field("red_info_led", 32'(want.red_info), 32'(m_red_info_led));
                    check_field("service_mode", 32'(want.service), 32'(m_service_mode));
                    reports_checked++;
                end
            end
            if (s_valid && s_ready) absorb_byte(s_rx_byte);
        end
        frames_due = report_q.size();
    end

endmodule

// ----- verif/tb_command_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// tb_command_frame_receiver_top
// Drives serial bytes into the command frame receiver: directed frames
// for every frame type, unknown types, bad checksums, repeated and broken
// headers, then random frames mixed with noise. The sender runs in bursts
// with gaps, the result side stalls on its own pattern, and the checker
// module beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_command_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam int PAYLOAD     = PAYLOAD_BYTES_DEF;
    localparam int BYTE_TARGET = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 10;
    localparam int DRAIN_EVERY = 25;

    typedef enum int {RX_OPEN, RX_COIN, RX_HOLD} rx_mode_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte = 8'h00;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic              m_checksum_ok;
    logic [7:0]        m_frame_type;
    logic              m_clear_counters;
    logic [DOSE_W-1:0] m_dose_value;
    logic [7:0]        m_ventilation_on;
    logic [7:0]        m_blue_led_on;
    logic [7:0]        m_right_sensor_enable;
    logic [7:0]        m_left_sensor_enable;
    logic [7:0]        m_red_temp_led;
    logic [7:0]        m_red_info_led;
    logic [7:0]        m_service_mode;

    int mismatch_count;
    int frames_due;
    int reports_checked;

    int       burst_left  = 0;
    int       bytes_sent  = 0;
    int       frames_sent = 0;
    int       cycle_count = 0;
    rx_mode_t rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    command_frame_receiver_top dut (.*);

    command_frame_receiver_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_command_frame_receiver_top failed");
            $finish;
        end
    end

    // result side stall pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= 1'b0;
        endcase
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // hold the sender until every pending frame report is out
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (frames_due != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] a1,
                              input logic [7:0] a2, input bit good_sum,
                              input int dollars, input bit hdr_fill);
        logic [7:0] body [PAYLOAD];
        logic [7:0] sum;
        body[0] = ftype;
        body[1] = a1;
        body[2] = a2;
        for (int i = 3; i < PAYLOAD - 1; i++) begin
            if (hdr_fill) body[i] = (i % 2) ? HDR_FIRST : HDR_SECOND;
            else body[i] = 8'($urandom_range(0, 255));
        end
        sum = '0;
        for (int i = 0; i < PAYLOAD - 1; i++) sum ^= body[i];
        body[PAYLOAD-1] = good_sum ? sum : sum ^ 8'(1 << $urandom_range(0, 7));
        repeat (dollars) push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        for (int i = 0; i < PAYLOAD; i++) push_byte(body[i]);
        frames_sent++;
    endtask

    function automatic logic [7:0] pick_arg();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return 8'h00;
        if (roll < 4) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_frame();
        int         noise;
        int         roll;
        logic [7:0] ftype;
        noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0;
        repeat (noise) push_byte(8'($urandom_range(0, 255)));
        // broken header
        if ($urandom_range(0, 9) == 0) begin
            push_byte(HDR_FIRST);
            push_byte(8'($urandom_range(0, 255)));
        end
        roll = $urandom_range(0, 19);
        if (roll < 15) ftype = 8'($urandom_range(0, 7));
        else if (roll < 18) ftype = 8'($urandom_range(8, 15));
        else ftype = 8'($urandom_range(0, 255));
        send_frame(ftype, pick_arg(), pick_arg(), $urandom_range(0, 99) < 85,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1,
                   $urandom_range(0, 9) == 0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // stray bytes, lone second header byte, broken header
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(HDR_SECOND);
        push_byte(HDR_FIRST);
        push_byte(8'h41);

        send_frame(TYPE_CLEAR, 8'h00, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_DOSE, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_VENTILATION, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_BLUE_LED, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_SENSORS, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_RED_TEMP, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_RED_INFO, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(TYPE_SERVICE, 8'hFF, 8'h00, 1'b1, 1, 1'b0);
        send_frame(8'd8, 8'h55, 8'hAA, 1'b1, 1, 1'b0);
        send_frame(8'hFF, 8'hAA, 8'h55, 1'b1, 1, 1'b0);
        send_frame(TYPE_DOSE, 8'h00, 8'h00, 1'b0, 1, 1'b0);
        send_frame(TYPE_CLEAR, 8'h00, 8'h00, 1'b0, 1, 1'b0);
        send_frame(TYPE_DOSE, 8'h00, 8'h00, 1'b1, 3, 1'b0);
        send_frame(TYPE_SERVICE, 8'h00, 8'h00, 1'b1, 1, 1'b1);
        send_frame(TYPE_SENSORS, 8'h00, 8'hFF, 1'b1, 2, 1'b0);
        drain();

        while (bytes_sent < BYTE_TARGET) begin
            random_frame();
            if (frames_sent % DRAIN_EVERY == 0) drain();
        end
        drain();

        $display("run covered %0d bytes and %0d frames, %0d results checked",
                 bytes_sent, frames_sent, reports_checked);
        $display("frame types 0 to 7, unknown types, bad checksums, noise and odd headers");
        if (mismatch_count == 0 && frames_due == 0) begin
            $display("tb_command_frame_receiver_top passed");
        end else begin
            $display("tb_command_frame_receiver_top failed");
        end
        $finish;
    end

endmodule
